/* rtl/lzw_compressor_macros.svh */
// Assertion macros for the LZW compressor checker.
// Used by lzw_compressor_chk only; needs a clock named i_clk and reset i_rst_n.
`ifndef LZW_COMPRESSOR_MACROS_SVH
`define LZW_COMPRESSOR_MACROS_SVH

// Clocked assertion, quiet while reset is held
`define LZW_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("lzw assertion failed");

// Clocked assertion that also checks across reset
`define LZW_ASSERT_RST(label, prop) \
    label: assert property (@(posedge i_clk) (prop)) \
        else $error("lzw reset assertion failed");

`endif

/* rtl/lzw_pkg.sv */
// Shared constants and controller/datapath interface types for the LZW compressor.
// No dependencies.
package lzw_pkg;

    localparam int CODE_BITS  = 12;
    localparam int NFC_BITS   = 17;
    localparam logic [NFC_BITS-1:0] TABLE_SIZE  = NFC_BITS'(1) << CODE_BITS;
    localparam logic [15:0]         FLUSH_CODE  = 16'd256;
    localparam logic [NFC_BITS-1:0] FIRST_CODE  = NFC_BITS'(257);
    localparam logic [15:0]         MAX_CODE_RST = 16'd4095;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;   // input beat accepted
        logic rd;     // read dictionary entry at search index
        logic nxt;    // advance search index
        logic hit;    // search matched
        logic miss;   // search exhausted
        logic adv;    // output beat taken
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic held;      // a prefix is held
        logic in_last;   // last mark on the input port
        logic last;      // latched last mark
        logic more;      // search index below next free code
        logic match;     // read key equals search key
        logic emit_last; // current output beat is the final one
    } t_sts;

endpackage

/* rtl/lzw_datapath.sv */
// Datapath of the LZW compressor: dictionary memory, prefix, code counter, result list.
// Depends on lzw_pkg.
module lzw_datapath (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr_en,
    input  logic [15:0]        i_cfg_wr_data,
    input  logic [7:0]         i_data_byte,
    input  logic               i_last_byte,
    input  lzw_pkg::t_cmd      i_cmd,
    output lzw_pkg::t_sts      o_sts,
    output logic [15:0]        o_code_word
);

    logic [23:0] r_mem [lzw_pkg::TABLE_SIZE];
    logic [23:0] r_rdata;
    logic [15:0] r_prefix;
    logic        r_held;
    logic [lzw_pkg::NFC_BITS-1:0] r_nfc;
    logic [lzw_pkg::NFC_BITS-1:0] r_idx;
    logic [15:0] r_max;
    logic [7:0]  r_byte;
    logic        r_last;
    logic [15:0] r_out [3];
    logic [1:0]  r_cnt;
    logic [1:0]  r_oi;

    logic [23:0] key;
    logic [lzw_pkg::NFC_BITS-1:0] limit;
    logic        room;

    assign key   = {r_prefix, r_byte};
    assign limit = ({1'b0, r_max} < (lzw_pkg::TABLE_SIZE - 1'b1)) ?
                   {1'b0, r_max} : (lzw_pkg::TABLE_SIZE - 1'b1);
    assign room  = (r_nfc <= limit);

    // Dictionary memory: one write or one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.miss && room) begin
            r_mem[r_nfc[lzw_pkg::CODE_BITS-1:0]] <= key;
        end
        if (i_cmd.rd) begin
            r_rdata <= r_mem[r_idx[lzw_pkg::CODE_BITS-1:0]];
        end
    end

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max <= lzw_pkg::MAX_CODE_RST;
        end else if (i_cfg_wr_en) begin
            r_max <= i_cfg_wr_data;
        end
    end

    // Payload latches and search index
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_byte <= i_data_byte;
            r_last <= i_last_byte;
            r_idx  <= lzw_pkg::FIRST_CODE;
            r_oi   <= 2'd0;
        end
        if (i_cmd.nxt) begin
            r_idx <= r_idx + 1'b1;
        end
        if (i_cmd.adv) begin
            r_oi <= r_oi + 2'd1;
        end
    end

    // Prefix, code counter and result list
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prefix <= '0;
            r_held   <= 1'b0;
            r_nfc    <= lzw_pkg::FIRST_CODE;
        end else if (i_cmd.load && !r_held) begin
            if (i_last_byte) begin
                r_out[0] <= {8'd0, i_data_byte};
                r_cnt    <= 2'd1;
                r_prefix <= '0;
            end else begin
                r_prefix <= {8'd0, i_data_byte};
                r_held   <= 1'b1;
            end
        end else if (i_cmd.hit) begin
            if (r_last) begin
                r_out[0] <= r_idx[15:0];
                r_cnt    <= 2'd1;
                r_prefix <= '0;
                r_held   <= 1'b0;
                r_nfc    <= lzw_pkg::FIRST_CODE;
            end else begin
                r_prefix <= r_idx[15:0];
            end
        end else if (i_cmd.miss) begin
            r_out[0] <= r_prefix;
            r_out[1] <= {8'd0, r_byte};
            if (!room) begin
                r_out[2] <= lzw_pkg::FLUSH_CODE;
                r_cnt    <= 2'd3;
                r_prefix <= '0;
                r_held   <= 1'b0;
                r_nfc    <= lzw_pkg::FIRST_CODE;
            end else if (r_last) begin
                r_cnt    <= 2'd2;
                r_prefix <= '0;
                r_held   <= 1'b0;
                r_nfc    <= lzw_pkg::FIRST_CODE;
            end else begin
                r_cnt    <= 2'd1;
                r_prefix <= {8'd0, r_byte};
                r_nfc    <= r_nfc + 1'b1;
            end
        end
    end

    assign o_sts.held      = r_held;
    assign o_sts.in_last   = i_last_byte;
    assign o_sts.last      = r_last;
    assign o_sts.more      = (r_idx < r_nfc);
    assign o_sts.match     = (r_rdata == key);
    assign o_sts.emit_last = (r_oi == (r_cnt - 2'd1));
    assign o_code_word     = r_out[r_oi];

endmodule

/* rtl/lzw_ctrl.sv */
// Controller of the LZW compressor: accept, linear dictionary search, code emission.
// Depends on lzw_pkg.
module lzw_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    output logic          o_valid,
    input  logic          i_ready,
    input  lzw_pkg::t_sts i_sts,
    output lzw_pkg::t_cmd o_cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;
    localparam logic [2:0] S_CMP  = 3'd2;
    localparam logic [2:0] S_EMIT = 3'd3;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        o_valid = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_sts.held) begin
                        n_state = S_RD;
                    end else if (i_sts.in_last) begin
                        n_state = S_EMIT;
                    end
                end
            end
            S_RD: begin
                if (i_sts.more) begin
                    o_cmd.rd = 1'b1;
                    n_state  = S_CMP;
                end else begin
                    o_cmd.miss = 1'b1;
                    n_state    = S_EMIT;
                end
            end
            S_CMP: begin
                if (i_sts.match) begin
                    o_cmd.hit = 1'b1;
                    n_state   = i_sts.last ? S_EMIT : S_IDLE;
                end else begin
                    o_cmd.nxt = 1'b1;
                    n_state   = S_RD;
                end
            end
            S_EMIT: begin
                o_valid = 1'b1;
                if (i_ready) begin
                    o_cmd.adv = 1'b1;
                    if (i_sts.emit_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

/* rtl/lzw_compressor.sv */
// LZW compressor: one byte per input beat, 0..3 codes per byte on the output channel.
// A byte with no prefix held is latched at once; else each dictionary entry is read and
// compared in turn (linear search over codes 257..next free code-1 in the single-port memory)
// until a match or a miss; a miss or the last byte emits codes. Takes one byte at a time.
// Reset (synchronous, active low) empties the dictionary via the code counter and
// restores max_code to 4095; no clearing pass is needed.
module lzw_compressor (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [15:0] i_cfg_wr_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [15:0] o_code_word,
    output logic        o_run_end
);

    lzw_pkg::t_cmd cmd;
    lzw_pkg::t_sts sts;

    lzw_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    lzw_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_data_byte   (i_data_byte),
        .i_last_byte   (i_last_byte),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .o_code_word   (o_code_word)
    );

    assign o_run_end = sts.emit_last;

endmodule

/* rtl/lzw_compressor_chk.sv */
// Port-level checker for the LZW compressor, bound to the top level.
// Depends on lzw_compressor_macros.svh.
`include "lzw_compressor_macros.svh"

module lzw_compressor_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [15:0] o_code_word,
    input logic        o_run_end
);

    // Never take a byte while codes are pending
    `LZW_ASSERT(a_no_overlap, !(o_ready && o_valid))
    // Stalled output beat holds
    `LZW_ASSERT(a_out_hold, o_valid && !i_ready |=> o_valid && $stable(o_code_word))
    // Final code of a byte returns to accepting
    `LZW_ASSERT(a_end_idle, o_valid && i_ready && o_run_end |=> o_ready && !o_valid)
    // Ready straight out of reset
    `LZW_ASSERT_RST(a_rst_ready, !i_rst_n |=> o_ready && !o_valid)

endmodule

bind lzw_compressor lzw_compressor_chk u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (i_valid),
    .o_ready     (o_ready),
    .o_valid     (o_valid),
    .i_ready     (i_ready),
    .o_code_word (o_code_word),
    .o_run_end   (o_run_end)
);
